>>> hdl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

	// table geometry
	localparam int SLOTS  = 64;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// field widths
	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 16;
	localparam int GEN_W   = 32;
	localparam int STAT_W  = 2;
	localparam int OIDX_W  = 6;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [GEN_W-1:0]  gen_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_LOOKUP  = 2'd1,
		FUNC_RELEASE = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

endpackage

>>> hdl/ght_req_if.sv
`timescale 1ns / 1ps

interface ght_req_if;
	logic                        valid;
	logic                        ready;
	logic [ght_pkg::FUNC_W-1:0]  func;
	logic [ght_pkg::IDX_W-1:0]   slot_index;
	logic [ght_pkg::GEN_W-1:0]   handle_generation;

	modport source (output valid, func, slot_index, handle_generation, input ready);
	modport sink   (input valid, func, slot_index, handle_generation, output ready);
endinterface

>>> hdl/ght_rsp_if.sv
`timescale 1ns / 1ps

interface ght_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ght_pkg::STAT_W-1:0]  status;
	logic [ght_pkg::OIDX_W-1:0]  out_index;
	logic [ght_pkg::GEN_W-1:0]   out_generation;

	modport source (output valid, status, out_index, out_generation, input ready);
	modport sink   (input valid, status, out_index, out_generation, output ready);
endinterface

>>> hdl/generational_handle_table.sv
`timescale 1ns / 1ps
// a request word is held in the request stage registers, its result in the response register
// throughput: one word per cycle unless stalled, limited by one generation-memory read and write
// ready drops only while the response register is full and the sink holds ready low
// reset: arst_n clears occupied bits and generation valid bits at once, so every slot is free
// with generation zero right after reset; there is no clearing pass

module generational_handle_table (
	input logic       clk,
	input logic       arst_n,
	ght_req_if.sink   req,
	ght_rsp_if.source rsp
);

	localparam int SLOTS  = ght_pkg::SLOTS;
	localparam int SLOT_W = ght_pkg::SLOT_W;
	localparam int IDX_W  = ght_pkg::IDX_W;
	localparam int GEN_W  = ght_pkg::GEN_W;
	localparam int OIDX_W = ght_pkg::OIDX_W;

	// slot state: occupied bits and generation valid bits in flops, generations in memory
	logic [SLOTS-1:0]     occ_q;
	logic [SLOTS-1:0]     gen_vld_q;
	ght_pkg::gen_t        gen_mem [SLOTS];

	// request stage
	logic                 s1_vld_s1;
	ght_pkg::func_t       func_s1;
	logic [IDX_W-1:0]     idx_s1;
	ght_pkg::gen_t        hgen_s1;
	ght_pkg::slot_t       alloc_slot_s1;
	logic                 full_s1;
	ght_pkg::gen_t        rd_gen_s1;
	logic                 rd_vld_s1;
	logic                 byp_s1;
	ght_pkg::gen_t        byp_gen_s1;

	// response register
	logic                 out_vld_q;
	ght_pkg::status_t     out_status_q;
	logic [OIDX_W-1:0]    out_index_q;
	ght_pkg::gen_t        out_gen_q;

	logic                 in_fire;
	logic                 s1_fire;
	ght_pkg::gen_t        cur_gen;
	logic                 in_range;
	logic                 handle_ok;
	logic                 wr_en;
	ght_pkg::slot_t       wr_addr;
	ght_pkg::gen_t        wr_data;
	logic                 set_occ;
	logic                 clr_occ;
	logic [SLOTS-1:0]     occ_next;
	ght_pkg::slot_t       free_slot;
	logic                 none_free;
	ght_pkg::slot_t       rd_addr;
	ght_pkg::status_t     res_status;
	logic [OIDX_W-1:0]    res_index;
	ght_pkg::gen_t        res_gen;
	logic [IDX_W-1:0]     slot_ext;

	// handshake: the request stage moves on when the response register is free or drains
	assign s1_fire   = s1_vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !s1_vld_s1 || s1_fire;
	assign in_fire   = req.valid && req.ready;

	// current generation of the addressed slot, with bypass of the write at the accept edge
	assign cur_gen  = byp_s1 ? byp_gen_s1 : (rd_vld_s1 ? rd_gen_s1 : '0);
	assign in_range = idx_s1 < IDX_W'(SLOTS);
	assign handle_ok = in_range && occ_q[idx_s1[SLOT_W-1:0]] && (cur_gen == hgen_s1);
	assign slot_ext = IDX_W'(alloc_slot_s1);

	// decision for the word in the request stage
	always_comb begin
		res_status = ght_pkg::ST_BAD;
		res_index  = idx_s1[OIDX_W-1:0];
		res_gen    = '0;
		set_occ    = 1'b0;
		clr_occ    = 1'b0;
		wr_addr    = idx_s1[SLOT_W-1:0];
		wr_data    = cur_gen + GEN_W'(1);
		unique case (func_s1)
			ght_pkg::FUNC_ALLOC: begin
				res_index = '0;
				wr_addr   = alloc_slot_s1;
				if (full_s1) begin
					res_status = ght_pkg::ST_FULL;
				end else begin
					res_status = ght_pkg::ST_OK;
					res_index  = slot_ext[OIDX_W-1:0];
					res_gen    = wr_data;
					set_occ    = 1'b1;
				end
			end
			ght_pkg::FUNC_LOOKUP: begin
				if (handle_ok) begin
					res_status = ght_pkg::ST_OK;
				end
			end
			ght_pkg::FUNC_RELEASE: begin
				if (handle_ok) begin
					res_status = ght_pkg::ST_OK;
					clr_occ    = 1'b1;
				end
			end
			default: begin
				// unused operation code answers as a bad handle
			end
		endcase
	end

	assign wr_en = s1_fire && (set_occ || clr_occ);

	// occupancy as the next request will see it
	always_comb begin
		occ_next = occ_q;
		if (s1_fire && set_occ) begin
			occ_next[wr_addr] = 1'b1;
		end
		if (s1_fire && clr_occ) begin
			occ_next[wr_addr] = 1'b0;
		end
	end

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occ_next[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end
	assign none_free = &occ_next;

	assign rd_addr = (ght_pkg::func_t'(req.func) == ght_pkg::FUNC_ALLOC) ?
		free_slot : req.slot_index[SLOT_W-1:0];

	// slot state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			gen_vld_q <= '0;
		end else begin
			occ_q <= occ_next;
			if (wr_en) begin
				gen_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// generation memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			gen_mem[wr_addr] <= wr_data;
		end
		if (in_fire) begin
			rd_gen_s1 <= gen_mem[rd_addr];
		end
	end

	// request stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			s1_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1       <= ght_pkg::func_t'(req.func);
			idx_s1        <= req.slot_index;
			hgen_s1       <= req.handle_generation;
			alloc_slot_s1 <= free_slot;
			full_s1       <= none_free;
			rd_vld_s1     <= gen_vld_q[rd_addr];
			byp_s1        <= wr_en && (wr_addr == rd_addr);
			byp_gen_s1    <= wr_data;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_status_q <= res_status;
			out_index_q  <= res_index;
			out_gen_q    <= res_gen;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.out_index      = out_index_q;
	assign rsp.out_generation = out_gen_q;

	// a successful allocate leaves its slot occupied
	a_alloc_sets_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && set_occ) |=> occ_q[$past(wr_addr)])
		else $error("allocated slot not marked occupied");

	// a successful release leaves its slot free
	a_release_clears_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && clr_occ) |=> !occ_q[$past(wr_addr)])
		else $error("released slot still occupied");

	// full is only reported when every slot was taken
	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && func_s1 == ght_pkg::FUNC_ALLOC && full_s1) |-> (&occ_q))
		else $error("table full reported with a free slot");

	// failed requests carry no generation
	a_fail_gen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_status_q != ght_pkg::ST_OK) |-> (out_gen_q == '0))
		else $error("failed request returned a generation");

endmodule
